// File: src/kct_pkg.sv
// ----------------------------------------------------------------------------
// kct_pkg
// Shared sizes, codes and controller/datapath interface types for the
// sorted k-mer count table.
// ----------------------------------------------------------------------------
`default_nettype none

package kct_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned COUNT_SETS    = 4;
  localparam int unsigned COUNT_BITS    = 16;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned IDX_W     = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W    = IDX_W + 1;
  localparam int unsigned SET_IDX_W = (COUNT_SETS > 1) ? $clog2(COUNT_SETS) : 1;

  // fixed port field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SET_W      = 2;
  localparam int unsigned OUT_CNT_W  = 16;
  localparam int unsigned OUT_IDX_W  = 12;
  localparam int unsigned STATUS_W   = 2;

  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [USED_W-1:0]     USED_MAX = USED_W'(TABLE_ENTRIES);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef count_t [COUNT_SETS-1:0] count_row_t;

  // request command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } kct_cmd_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_FULL  = 2'd2
  } kct_status_t;

  // read address source
  typedef enum logic {
    RA_MID,
    RA_LAST
  } kct_rd_sel_t;

  // binary search bound update
  typedef enum logic [1:0] {
    SR_HOLD,
    SR_INIT,
    SR_STEP
  } kct_srch_op_t;

  // count memory write operation
  typedef enum logic [1:0] {
    CW_NONE,
    CW_BUMP,
    CW_INIT,
    CW_ZERO
  } kct_cnt_wop_t;

  // count memory write address source
  typedef enum logic [1:0] {
    WA_LO,
    WA_LAST,
    WA_USED,
    WA_CLR
  } kct_wr_sel_t;

  // result kind loaded into the output register
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ORDER,
    RES_FULL,
    RES_LOAD_NEW,
    RES_LOAD_REP,
    RES_HIT
  } kct_res_t;

  // controller to datapath commands
  typedef struct packed {
    logic         cap_in;
    logic         rd_en;
    kct_rd_sel_t  rd_sel;
    kct_srch_op_t srch_op;
    logic         key_we;
    kct_cnt_wop_t cnt_wop;
    kct_wr_sel_t  wr_sel;
    logic         used_inc;
    logic         clr_init;
    logic         clr_inc;
    logic         res_load;
    kct_res_t     res_kind;
  } kct_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic srch_more;
    logic hit;
    logic used_zero;
    logic last_eq;
    logic last_lt;
    logic full;
    logic clr_more;
    logic is_count;
    logic set_ok;
  } kct_stat_t;

endpackage

`default_nettype wire

// File: src/kct_datapath.sv
// ----------------------------------------------------------------------------
// kct_datapath
// Key and count memories, search bounds, entry counter, clear pointer and
// the result register of the k-mer count table.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_datapath import kct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire kct_ctl_t             ctl,
  output kct_stat_t                 stat,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [KEY_W-1:0]     in_kmer_key,
  input  wire logic [SET_W-1:0]     in_count_set,
  output logic                      res_found,
  output logic [OUT_CNT_W-1:0]      res_count_value,
  output logic [OUT_IDX_W-1:0]      res_entry_index,
  output logic [STATUS_W-1:0]       res_status
);

  // memories
  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  count_row_t       cnt_mem [TABLE_ENTRIES];

  // captured request
  kct_cmd_t         cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [SET_W-1:0] set_r;

  // registered read data
  logic [KEY_W-1:0] key_rd_r;
  count_row_t       cnt_rd_r;

  // search and table state
  logic [USED_W-1:0] used_r, used_nxt;
  logic [USED_W-1:0] lo_r, hi_r, mid_r;
  logic [USED_W-1:0] lo_nxt, hi_nxt, mid_nxt;
  logic [USED_W-1:0] lo_step, hi_step;
  logic [USED_W-1:0] clr_ptr_r, clr_ptr_nxt;

  logic [IDX_W-1:0]     last_idx, rd_addr, wr_addr;
  logic [SET_IDX_W-1:0] set_idx, act_set;
  logic                 set_ok;
  count_t               cur_cnt, bumped;
  logic [COUNT_SETS-1:0] cnt_we;
  count_row_t           cnt_wd;

  // result register
  logic                 res_found_r, res_found_nxt;
  logic [OUT_CNT_W-1:0] res_count_r, res_count_nxt;
  logic [OUT_IDX_W-1:0] res_index_r, res_index_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;

  assign last_idx = IDX_W'(used_r - USED_W'(1));
  assign set_idx  = SET_IDX_W'(set_r);
  assign set_ok   = 32'(set_r) < 32'(COUNT_SETS);
  assign act_set  = (cmd_r == CMD_LOAD) ? '0 : set_idx;

  // saturating increment of the selected counter
  assign cur_cnt = cnt_rd_r[act_set];
  assign bumped  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + count_t'(1);

  // binary search bounds
  always_comb begin
    lo_step = lo_r;
    hi_step = hi_r;
    if (key_rd_r < key_r) begin
      lo_step = mid_r + USED_W'(1);
    end else begin
      hi_step = mid_r;
    end
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    case (ctl.srch_op)
      SR_INIT: begin
        lo_nxt = '0;
        hi_nxt = used_r;
      end
      SR_STEP: begin
        lo_nxt = lo_step;
        hi_nxt = hi_step;
      end
      default: begin
      end
    endcase
    mid_nxt = lo_nxt + ((hi_nxt - lo_nxt) >> 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_op != SR_HOLD) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      mid_r <= mid_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.cap_in) begin
      cmd_r <= kct_cmd_t'(in_command);
      key_r <= in_kmer_key;
      set_r <= in_count_set;
    end
  end

  // entry counter and clear pointer
  assign used_nxt    = ctl.used_inc ? used_r + USED_W'(1) : used_r;
  assign clr_ptr_nxt = ctl.clr_init ? '0 :
                       ctl.clr_inc  ? clr_ptr_r + USED_W'(1) : clr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    clr_ptr_r <= clr_ptr_nxt;
  end

  // memory read, shared address for keys and counts
  assign rd_addr = (ctl.rd_sel == RA_LAST) ? last_idx : IDX_W'(mid_nxt);

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      key_rd_r <= key_mem[rd_addr];
      cnt_rd_r <= cnt_mem[rd_addr];
    end
  end

  // key write on append
  always_ff @(posedge clk) begin
    if (ctl.key_we) begin
      key_mem[IDX_W'(used_r)] <= key_r;
    end
  end

  // count write enables and data per set
  always_comb begin
    unique case (ctl.wr_sel)
      WA_LO:   wr_addr = IDX_W'(lo_r);
      WA_LAST: wr_addr = last_idx;
      WA_USED: wr_addr = IDX_W'(used_r);
      WA_CLR:  wr_addr = IDX_W'(clr_ptr_r);
      default: wr_addr = IDX_W'(lo_r);
    endcase
    for (int s = 0; s < COUNT_SETS; s++) begin
      cnt_we[s] = 1'b0;
      cnt_wd[s] = '0;
      case (ctl.cnt_wop)
        CW_BUMP: begin
          cnt_we[s] = (SET_IDX_W'(s) == act_set);
          cnt_wd[s] = bumped;
        end
        CW_INIT: begin
          cnt_we[s] = 1'b1;
          cnt_wd[s] = (s == 0) ? count_t'(1) : '0;
        end
        CW_ZERO: begin
          cnt_we[s] = (SET_IDX_W'(s) == set_idx);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < COUNT_SETS; s++) begin
      if (cnt_we[s]) begin
        cnt_mem[wr_addr][s] <= cnt_wd[s];
      end
    end
  end

  // status toward the controller
  always_comb begin
    stat.srch_more = lo_step < hi_step;
    stat.hit       = (lo_r < used_r) && (key_rd_r == key_r);
    stat.used_zero = (used_r == '0);
    stat.last_eq   = (key_rd_r == key_r);
    stat.last_lt   = (key_r < key_rd_r);
    stat.full      = (used_r >= USED_MAX);
    stat.clr_more  = set_ok && (clr_ptr_r < used_r);
    stat.is_count  = (cmd_r == CMD_COUNT);
    stat.set_ok    = set_ok;
  end

  // result fields for the selected kind
  always_comb begin
    res_found_nxt  = 1'b0;
    res_count_nxt  = '0;
    res_index_nxt  = '0;
    res_status_nxt = ST_OK;
    unique case (ctl.res_kind)
      RES_ORDER: res_status_nxt = ST_ORDER;
      RES_FULL:  res_status_nxt = ST_FULL;
      RES_LOAD_NEW: begin
        res_found_nxt = 1'b1;
        res_count_nxt = OUT_CNT_W'(1);
        res_index_nxt = OUT_IDX_W'(used_r);
      end
      RES_LOAD_REP: begin
        res_found_nxt = 1'b1;
        res_count_nxt = OUT_CNT_W'(bumped);
        res_index_nxt = OUT_IDX_W'(last_idx);
      end
      RES_HIT: begin
        res_found_nxt = 1'b1;
        res_index_nxt = OUT_IDX_W'(lo_r);
        if (set_ok) begin
          res_count_nxt = (cmd_r == CMD_COUNT) ? OUT_CNT_W'(bumped)
                                               : OUT_CNT_W'(cur_cnt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      res_found_r  <= res_found_nxt;
      res_count_r  <= res_count_nxt;
      res_index_r  <= res_index_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign res_found       = res_found_r;
  assign res_count_value = res_count_r;
  assign res_entry_index = res_index_r;
  assign res_status      = res_status_r;

endmodule

`default_nettype wire

// File: src/kct_ctrl.sv
// ----------------------------------------------------------------------------
// kct_ctrl
// Request sequencer of the k-mer count table: load decision, binary search
// steps, clear sweep and output register handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module kct_ctrl import kct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output kct_ctl_t              ctl,
  input  wire kct_stat_t        stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SRCH = 5'b00010,
    S_CHK  = 5'b00100,
    S_LOAD = 5'b01000,
    S_CLR  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept, out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    ctl.cap_in   = 1'b0;
    ctl.rd_en    = 1'b0;
    ctl.rd_sel   = RA_MID;
    ctl.srch_op  = SR_HOLD;
    ctl.key_we   = 1'b0;
    ctl.cnt_wop  = CW_NONE;
    ctl.wr_sel   = WA_LO;
    ctl.used_inc = 1'b0;
    ctl.clr_init = 1'b0;
    ctl.clr_inc  = 1'b0;
    ctl.res_load = 1'b0;
    ctl.res_kind = RES_ZERO;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.cap_in = 1'b1;
          unique case (kct_cmd_t'(in_command)) inside
            CMD_LOAD: begin
              ctl.rd_en  = 1'b1;
              ctl.rd_sel = RA_LAST;
              state_nxt  = S_LOAD;
            end
            CMD_COUNT, CMD_QUERY: begin
              ctl.srch_op = SR_INIT;
              ctl.rd_en   = 1'b1;
              // empty table has nothing to search
              state_nxt   = stat.used_zero ? S_CHK : S_SRCH;
            end
            CMD_CLEAR: begin
              ctl.clr_init = 1'b1;
              state_nxt    = S_CLR;
            end
            default: begin
            end
          endcase
        end
      end
      // one halving per cycle, last read lands on the lower bound
      S_SRCH: begin
        ctl.srch_op = SR_STEP;
        ctl.rd_en   = 1'b1;
        if (!stat.srch_more) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          state_nxt    = S_IDLE;
          if (stat.hit) begin
            ctl.res_kind = RES_HIT;
            if (stat.is_count && stat.set_ok) begin
              ctl.cnt_wop = CW_BUMP;
              ctl.wr_sel  = WA_LO;
            end
          end
        end
      end
      // compare against the last loaded key
      S_LOAD: begin
        if (out_free) begin
          ctl.res_load = 1'b1;
          state_nxt    = S_IDLE;
          if (!stat.used_zero && stat.last_eq) begin
            ctl.res_kind = RES_LOAD_REP;
            ctl.cnt_wop  = CW_BUMP;
            ctl.wr_sel   = WA_LAST;
          end else if (!stat.used_zero && stat.last_lt) begin
            ctl.res_kind = RES_ORDER;
          end else if (stat.full) begin
            ctl.res_kind = RES_FULL;
          end else begin
            ctl.res_kind = RES_LOAD_NEW;
            ctl.key_we   = 1'b1;
            ctl.cnt_wop  = CW_INIT;
            ctl.wr_sel   = WA_USED;
            ctl.used_inc = 1'b1;
          end
        end
      end
      // zero one set, one entry per cycle
      S_CLR: begin
        if (stat.clr_more) begin
          ctl.cnt_wop = CW_ZERO;
          ctl.wr_sel  = WA_CLR;
          ctl.clr_inc = 1'b1;
        end else if (out_free) begin
          ctl.res_load = 1'b1;
          ctl.res_kind = RES_ZERO;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    if (ctl.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/kmer_count_table.sv
// ----------------------------------------------------------------------------
// kmer_count_table
// Sorted table of 64-bit k-mer keys with saturating per-set counters;
// load, count, query and clear requests.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  in_      | input     | in_valid/in_stall  | command, kmer_key, count_set
//  out_     | output    | out_valid/out_stall| found, count_value, entry_index,
//           |           |                    | status
//
//  Load reads the last key, then decides and writes.
//  Count and query do one key memory read per binary search step.
//  Clear does one counter write per used entry.
//  Reset clears only the entry count and control; the memories need no pass.
//  A waiting result does not block the next request; the request's final
//  cycle holds until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kmer_count_table import kct_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [CMD_W-1:0]     in_command,
  input  wire logic [KEY_W-1:0]     in_kmer_key,
  input  wire logic [SET_W-1:0]     in_count_set,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_found,
  output logic [OUT_CNT_W-1:0]      out_count_value,
  output logic [OUT_IDX_W-1:0]      out_entry_index,
  output logic [STATUS_W-1:0]       out_status
);

  kct_ctl_t  ctl;
  kct_stat_t stat;

  // sequencer
  kct_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .ctl        (ctl),
    .stat       (stat)
  );

  // memories and result register
  kct_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_command      (in_command),
    .in_kmer_key     (in_kmer_key),
    .in_count_set    (in_count_set),
    .res_found       (out_found),
    .res_count_value (out_count_value),
    .res_entry_index (out_entry_index),
    .res_status      (out_status)
  );

endmodule

`default_nettype wire
